@@ hdl/lacd_pkg.sv @@
// Shared types, command codes and helpers for the logic analyzer command decoder.
// No dependencies; used by lacd_decode and logic_analyzer_command_decoder.
package lacd_pkg;

  localparam int unsigned SAMPLES_DEFAULT = 4096;

  // action codes
  localparam logic [2:0] ACT_NONE  = 3'd0;
  localparam logic [2:0] ACT_RESET = 3'd1;
  localparam logic [2:0] ACT_RUN   = 3'd2;
  localparam logic [2:0] ACT_ID    = 3'd3;
  localparam logic [2:0] ACT_META  = 3'd4;
  localparam logic [2:0] ACT_EXIT  = 3'd5;

  // short commands
  localparam logic [7:0] CMD_RESET = 8'h00;
  localparam logic [7:0] CMD_RUN   = 8'h01;
  localparam logic [7:0] CMD_ID    = 8'h02;
  localparam logic [7:0] CMD_META  = 8'h04;
  localparam logic [7:0] CMD_ESC   = 8'h1B;

  // long commands
  localparam logic [7:0] OP_DIVIDER = 8'h80;
  localparam logic [7:0] OP_COUNTS  = 8'h81;
  localparam logic [7:0] OP_FLAGS   = 8'h82;
  localparam logic [7:0] OP_DELAY   = 8'h83;
  localparam logic [7:0] OP_READ    = 8'h84;
  localparam logic [3:0] OP_TRIG_HI = 4'hC;

  localparam logic [1:0] LAST_PARAM = 2'd3;

  typedef struct packed {
    logic [7:0]  opcode;     // zero: no long command open
    logic [1:0]  count;
    logic [23:0] params;
    logic [23:0] divider;
    logic [18:0] read_cnt;
    logic [18:0] delay_cnt;
    logic [31:0] flags;
    logic [2:0]  width;
  } state_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [23:0] clock_divider;
    logic [18:0] read_samples;
    logic [18:0] delay_samples;
    logic [31:0] flag_word;
    logic [2:0]  bytes_per_sample;
    logic        trig_write;
    logic [1:0]  trig_stage;
    logic        trig_is_value;
    logic [31:0] trig_word;
  } result_t;

  // ((v + 1) * 4); max 2^18 fits in 19 bits
  function automatic logic [18:0] count_of(input logic [15:0] v);
    logic [18:0] t;
    t = {3'b000, v} + 19'd1;
    return {t[16:0], 2'b00};
  endfunction

  // enabled groups are those with a clear disable bit in flags[5:2]
  function automatic logic [2:0] groups_enabled(input logic [3:0] dis);
    logic [2:0] n;
    n = {2'b00, ~dis[0]} + {2'b00, ~dis[1]} + {2'b00, ~dis[2]} + {2'b00, ~dis[3]};
    return (n == 3'd0) ? 3'd1 : n;
  endfunction

endpackage

@@ hdl/lacd_decode.sv @@
// Byte decoder: next parser/settings state and the result word for one host byte.
// Depends on lacd_pkg.
module lacd_decode #(
  parameter int unsigned DEFAULT_SAMPLES = lacd_pkg::SAMPLES_DEFAULT
) (
  input  lacd_pkg::state_t  state,
  input  logic [7:0]        rx_byte,
  output lacd_pkg::state_t  state_next,
  output lacd_pkg::result_t result
);

  localparam logic [18:0] DefCount = 19'(DEFAULT_SAMPLES);

  lacd_pkg::state_t clear_state;
  logic [31:0]      word;

  assign word = {rx_byte, state.params};

  always_comb begin
    clear_state           = '0;
    clear_state.read_cnt  = DefCount;
    clear_state.delay_cnt = DefCount;
    clear_state.width     = 3'd4;
  end

  always_comb begin
    lacd_pkg::result_t r;
    lacd_pkg::state_t  s;
    s = state;
    r = '0;
    r.action = lacd_pkg::ACT_NONE;

    if (rx_byte == lacd_pkg::CMD_ESC) begin
      s        = clear_state;
      r.action = lacd_pkg::ACT_EXIT;
    end else if (state.opcode != 8'h00) begin
      if (state.count != lacd_pkg::LAST_PARAM) begin
        case (state.count)
          2'd0:    s.params[7:0]   = rx_byte;
          2'd1:    s.params[15:8]  = rx_byte;
          default: s.params[23:16] = rx_byte;
        endcase
        s.count = state.count + 2'd1;
      end else begin
        case (state.opcode)
          lacd_pkg::OP_DIVIDER: s.divider = state.params;
          lacd_pkg::OP_COUNTS: begin
            s.read_cnt  = lacd_pkg::count_of(state.params[15:0]);
            s.delay_cnt = lacd_pkg::count_of({rx_byte, state.params[23:16]});
          end
          lacd_pkg::OP_FLAGS: begin
            s.flags = word;
            s.width = lacd_pkg::groups_enabled(word[5:2]);
          end
          lacd_pkg::OP_DELAY: s.delay_cnt = lacd_pkg::count_of(state.params[15:0]);
          lacd_pkg::OP_READ:  s.read_cnt  = lacd_pkg::count_of(state.params[15:0]);
          default: begin
            if (state.opcode[7:4] == lacd_pkg::OP_TRIG_HI) begin
              r.trig_write    = 1'b1;
              r.trig_stage    = state.opcode[3:2];
              r.trig_is_value = state.opcode[0];
              r.trig_word     = word;
            end
          end
        endcase
        s.opcode = 8'h00;
        s.count  = 2'd0;
        s.params = '0;
      end
    end else if (rx_byte[7]) begin
      s.opcode = rx_byte;
      s.count  = 2'd0;
      s.params = '0;
    end else begin
      case (rx_byte)
        lacd_pkg::CMD_RESET: begin
          s        = clear_state;
          r.action = lacd_pkg::ACT_RESET;
        end
        lacd_pkg::CMD_RUN:  r.action = lacd_pkg::ACT_RUN;
        lacd_pkg::CMD_ID:   r.action = lacd_pkg::ACT_ID;
        lacd_pkg::CMD_META: r.action = lacd_pkg::ACT_META;
        default:            r.action = lacd_pkg::ACT_NONE;
      endcase
    end

    r.clock_divider    = s.divider;
    r.read_samples     = s.read_cnt;
    r.delay_samples    = s.delay_cnt;
    r.flag_word        = s.flags;
    r.bytes_per_sample = s.width;
    state_next = s;
    result     = r;
  end

endmodule

@@ hdl/logic_analyzer_command_decoder.sv @@
// Top level of the logic analyzer command decoder: input byte register, decode,
// result register. Depends on lacd_pkg and lacd_decode.
//
//  channel | handshake          | payload
//  --------+--------------------+-------------------------------------------------
//  in      | in_valid, in_stall | rx_byte
//  out     | out_valid,out_stall| action, clock_divider, read_samples, delay_samples,
//          |                    | flag_word, bytes_per_sample, trig_write,
//          |                    | trig_stage, trig_is_value, trig_word
//
// One word per cycle sustained while out is not stalled; each byte passes the byte register, then the result register.
// The settings are updated as a byte moves from the byte register into the result register.
// rst (synchronous) empties both registers and returns parser and settings to reset values.
// A stall on out holds the result register; the byte register then fills and in_stall rises.
module logic_analyzer_command_decoder #(
  parameter int unsigned DEFAULT_SAMPLES = lacd_pkg::SAMPLES_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  action,
  output logic [23:0] clock_divider,
  output logic [18:0] read_samples,
  output logic [18:0] delay_samples,
  output logic [31:0] flag_word,
  output logic [2:0]  bytes_per_sample,
  output logic        trig_write,
  output logic [1:0]  trig_stage,
  output logic        trig_is_value,
  output logic [31:0] trig_word
);

  localparam logic [18:0] DefCount = 19'(DEFAULT_SAMPLES);

  logic               byte_valid;
  logic [7:0]         byte_reg;
  logic               advance;
  lacd_pkg::state_t   state;
  lacd_pkg::state_t   state_next;
  lacd_pkg::result_t  result_next;
  lacd_pkg::result_t  result;

  assign advance  = byte_valid && (!out_valid || !out_stall);
  assign in_stall = byte_valid && !advance;

  lacd_decode #(
    .DEFAULT_SAMPLES(DEFAULT_SAMPLES)
  ) u_decode (
    .state      (state),
    .rx_byte    (byte_reg),
    .state_next (state_next),
    .result     (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (!in_stall) begin
      byte_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      byte_reg <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{opcode: 8'h00, count: 2'd0, params: 24'h0, divider: 24'h0,
                 read_cnt: DefCount, delay_cnt: DefCount, flags: 32'h0, width: 3'd4};
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

  assign action           = result.action;
  assign clock_divider    = result.clock_divider;
  assign read_samples     = result.read_samples;
  assign delay_samples    = result.delay_samples;
  assign flag_word        = result.flag_word;
  assign bytes_per_sample = result.bytes_per_sample;
  assign trig_write       = result.trig_write;
  assign trig_stage       = result.trig_stage;
  assign trig_is_value    = result.trig_is_value;
  assign trig_word        = result.trig_word;

endmodule

@@ verif/lacd_checker.sv @@
// Checker for the logic analyzer command decoder: watches both channels, predicts each
// result word from the accepted host bytes and compares field by field. Uses lacd_pkg.
`timescale 1ns / 1ps

module lacd_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  rx_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  action,
  input  logic [23:0] clock_divider,
  input  logic [18:0] read_samples,
  input  logic [18:0] delay_samples,
  input  logic [31:0] flag_word,
  input  logic [2:0]  bytes_per_sample,
  input  logic        trig_write,
  input  logic [1:0]  trig_stage,
  input  logic        trig_is_value,
  input  logic [31:0] trig_word,
  output int          fail_count,
  output int          pending
);

  localparam int MAX_PRINTED = 40;

  // parser and settings as the host sees them
  logic [7:0]  open_op;
  logic [1:0]  n_par;
  logic [23:0] par_acc;
  logic [23:0] div_q;
  logic [18:0] rd_q;
  logic [18:0] dl_q;
  logic [31:0] flg_q;
  logic [2:0]  wid_q;

  lacd_pkg::result_t expected_words[$];
  int      errors = 0;
  int      n_out = 0;

  assign fail_count = errors;

  task automatic report_mismatch(input string msg);
    if (errors < MAX_PRINTED) $display("ERROR %0t: %s", $time, msg);
    errors++;
  endtask

  task automatic cmp_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("word %0d %s: got 0x%0h, expected 0x%0h", n_out, name, got,
                                want));
  endtask

  function automatic void clear_settings();
    open_op = '0;
    n_par   = '0;
    par_acc = '0;
    div_q   = '0;
    rd_q    = 19'(lacd_pkg::SAMPLES_DEFAULT);
    dl_q    = 19'(lacd_pkg::SAMPLES_DEFAULT);
    flg_q   = '0;
    wid_q   = 3'd4;
  endfunction

  function automatic logic [18:0] sample_count(input logic [7:0] lo, input logic [7:0] hi);
    logic [18:0] v;
    v = {3'b000, hi, lo} + 19'd1;
    return v << 2;
  endfunction

  // groups whose disable bit in flags[5:2] is clear, never below one
  function automatic logic [2:0] groups_on(input logic [31:0] f);
    logic [2:0] n;
    n = 3'd0;
    for (int i = 2; i < 6; i++)
      if (!f[i]) n = n + 3'd1;
    return (n == 3'd0) ? 3'd1 : n;
  endfunction

  function automatic lacd_pkg::result_t decode_byte(input logic [7:0] b);
    lacd_pkg::result_t r;
    logic [31:0]       full;
    r = '0;
    if (b == lacd_pkg::CMD_ESC) begin
      clear_settings();
      r.action = lacd_pkg::ACT_EXIT;
    end else if (open_op != 8'h00) begin
      if (n_par != lacd_pkg::LAST_PARAM) begin
        par_acc[8*n_par +: 8] = b;
        n_par = n_par + 2'd1;
      end else begin
        full = {b, par_acc};
        case (open_op)
          lacd_pkg::OP_DIVIDER: div_q = par_acc;
          lacd_pkg::OP_COUNTS: begin
            rd_q = sample_count(par_acc[7:0], par_acc[15:8]);
            dl_q = sample_count(par_acc[23:16], b);
          end
          lacd_pkg::OP_FLAGS: begin
            flg_q = full;
            wid_q = groups_on(full);
          end
          lacd_pkg::OP_DELAY: dl_q = sample_count(par_acc[7:0], par_acc[15:8]);
          lacd_pkg::OP_READ:  rd_q = sample_count(par_acc[7:0], par_acc[15:8]);
          default: begin
            if (open_op[7:4] == lacd_pkg::OP_TRIG_HI) begin
              r.trig_write    = 1'b1;
              r.trig_stage    = open_op[3:2];
              r.trig_is_value = open_op[0];
              r.trig_word     = full;
            end
          end
        endcase
        open_op = '0;
        n_par   = '0;
        par_acc = '0;
      end
    end else if (b[7]) begin
      open_op = b;
      n_par   = '0;
      par_acc = '0;
    end else begin
      case (b)
        lacd_pkg::CMD_RESET: begin
          clear_settings();
          r.action = lacd_pkg::ACT_RESET;
        end
        lacd_pkg::CMD_RUN:  r.action = lacd_pkg::ACT_RUN;
        lacd_pkg::CMD_ID:   r.action = lacd_pkg::ACT_ID;
        lacd_pkg::CMD_META: r.action = lacd_pkg::ACT_META;
        default:            r.action = lacd_pkg::ACT_NONE;
      endcase
    end
    r.clock_divider    = div_q;
    r.read_samples     = rd_q;
    r.delay_samples    = dl_q;
    r.flag_word        = flg_q;
    r.bytes_per_sample = wid_q;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    lacd_pkg::result_t want;
    if (rst) begin
      clear_settings();
      expected_words.delete();
      pending <= 0;
    end else begin
      // results leave through the byte and result registers, so check before queuing this edge's byte
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("word %0d arrived with nothing expected", n_out));
        end else begin
          want = expected_words.pop_front();
          cmp_field("action", 32'(action), 32'(want.action));
          cmp_field("clock_divider", 32'(clock_divider), 32'(want.clock_divider));
          cmp_field("read_samples", 32'(read_samples), 32'(want.read_samples));
          cmp_field("delay_samples", 32'(delay_samples), 32'(want.delay_samples));
          cmp_field("flag_word", flag_word, want.flag_word);
          cmp_field("bytes_per_sample", 32'(bytes_per_sample), 32'(want.bytes_per_sample));
          cmp_field("trig_write", 32'(trig_write), 32'(want.trig_write));
          cmp_field("trig_stage", 32'(trig_stage), 32'(want.trig_stage));
          cmp_field("trig_is_value", 32'(trig_is_value), 32'(want.trig_is_value));
          cmp_field("trig_word", trig_word, want.trig_word);
        end
        n_out++;
      end
      if (in_valid && !in_stall) expected_words.push_back(decode_byte(rx_byte));
      pending <= expected_words.size();
    end
  end

endmodule

@@ verif/testbench.sv @@
// Top of the command decoder testbench: clock, reset, host byte stimulus and result
// stalls, watchdog and verdict. Depends on lacd_pkg, the decoder and lacd_checker.
`timescale 1ns / 1ps

module testbench;

  localparam logic [7:0] FLOW_XON   = 8'h11;
  localparam logic [7:0] FLOW_XOFF  = 8'h13;
  localparam int         MAX_WAIT   = 18;
  localparam int         IDLE_LIMIT = 500;
  localparam int         N_BYTES    = 730;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  action;
  logic [23:0] clock_divider;
  logic [18:0] read_samples;
  logic [18:0] delay_samples;
  logic [31:0] flag_word;
  logic [2:0]  bytes_per_sample;
  logic        trig_write;
  logic [1:0]  trig_stage;
  logic        trig_is_value;
  logic [31:0] trig_word;

  int fail_count;
  int pending;
  int bytes_sent = 0;
  int stall_left = 0;
  int idle_cycles = 0;
  bit quiet = 1'b0;     // no idling on either side while set

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic_analyzer_command_decoder uut (
    .clk, .rst, .in_valid, .in_stall, .rx_byte, .out_valid, .out_stall,
    .action, .clock_divider, .read_samples, .delay_samples, .flag_word,
    .bytes_per_sample, .trig_write, .trig_stage, .trig_is_value, .trig_word
  );

  lacd_checker chk (
    .clk, .rst, .in_valid, .in_stall, .rx_byte, .out_valid, .out_stall,
    .action, .clock_divider, .read_samples, .delay_samples, .flag_word,
    .bytes_per_sample, .trig_write, .trig_stage, .trig_is_value, .trig_word,
    .fail_count, .pending
  );

  function automatic int draw_wait();
    return quiet ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  // receiver: a fresh stall length after every accepted result word
  always @(posedge clk) begin
    if (rst) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) stall_left = draw_wait();
      else if (stall_left != 0) stall_left = stall_left - 1;
      out_stall <= (stall_left != 0);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // called at an edge where the previous word was accepted (or reset ended);
  // returns at the edge that accepts this one
  task automatic push_byte(input logic [7:0] b);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  task automatic send_long(input logic [7:0] op, input logic [7:0] p0, input logic [7:0] p1,
                           input logic [7:0] p2, input logic [7:0] p3);
    push_byte(op);
    push_byte(p0);
    push_byte(p1);
    push_byte(p2);
    push_byte(p3);
  endtask

  function automatic logic [7:0] rand_param();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] rand_opcode();
    case ($urandom_range(0, 9))
      0: return lacd_pkg::OP_DIVIDER;
      1: return lacd_pkg::OP_COUNTS;
      2: return lacd_pkg::OP_FLAGS;
      3: return lacd_pkg::OP_DELAY;
      4: return lacd_pkg::OP_READ;
      5, 6: return {lacd_pkg::OP_TRIG_HI, 4'($urandom_range(0, 15))};
      default: return 8'h80 | 8'($urandom_range(0, 127));
    endcase
  endfunction

  function automatic logic [7:0] rand_short();
    case ($urandom_range(0, 7))
      0: return lacd_pkg::CMD_RESET;
      1: return lacd_pkg::CMD_RUN;
      2: return lacd_pkg::CMD_ID;
      3: return lacd_pkg::CMD_META;
      4: return FLOW_XON;
      5: return FLOW_XOFF;
      6: return lacd_pkg::CMD_ESC;
      default: return 8'($urandom_range(0, 127));
    endcase
  endfunction

  initial begin
    bit drained;
    int kind;
    drained = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    push_byte(lacd_pkg::CMD_ID);
    push_byte(lacd_pkg::CMD_META);
    push_byte(lacd_pkg::CMD_RUN);
    send_long(lacd_pkg::OP_DIVIDER, 8'hFF, 8'hFF, 8'hFF, 8'h5A);
    send_long(lacd_pkg::OP_COUNTS, 8'hFF, 8'hFF, 8'h00, 8'h00);
    send_long(lacd_pkg::OP_FLAGS, 8'h3C, 8'h00, 8'h00, 8'h80);     // every group disabled
    send_long({lacd_pkg::OP_TRIG_HI, 4'hD}, 8'h78, 8'h56, 8'h34, 8'h12);
    push_byte(lacd_pkg::CMD_RESET);
    push_byte(8'h85);
    push_byte(8'h01);
    push_byte(lacd_pkg::CMD_ESC);                                   // exit in mid-parameter

    while (bytes_sent < N_BYTES) begin
      quiet = ((bytes_sent / 64) % 4) == 1;
      if (!drained && bytes_sent >= N_BYTES / 2) begin
        drained = 1'b1;
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
      end
      kind = $urandom_range(0, 9);
      if (kind < 6) begin
        push_byte(rand_opcode());
        for (int i = 0; i < 4; i++) begin
          if ($urandom_range(0, 24) == 0) begin
            push_byte(lacd_pkg::CMD_ESC);
            break;
          end
          push_byte(rand_param());
        end
      end else if (kind < 9) begin
        push_byte(rand_short());
      end else begin
        push_byte(8'($urandom_range(0, 255)));
      end
    end
    in_valid <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
